FILE: rtl/sss_pkg.sv
// Shared types and constants for the signature sparse set.
// Used by the top level and the generic RAM; depends on nothing.
package sss_pkg;

    // Fixed port widths
    localparam int ID_W     = 10;
    localparam int MASK_W   = 32;
    localparam int ACT_W    = 2;
    localparam int CNT_OUT_W = 11;

    // Parameter defaults
    localparam int DEF_MAX_ENTITIES = 1024;
    localparam int DEF_MASK_WIDTH   = 32;

    // Result action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_NONE    = 2'd0,
        ACT_ADDED   = 2'd1,
        ACT_REMOVED = 2'd2
    } action_t;

endpackage

FILE: rtl/sss_ram.sv
// Generic single write port RAM with one registered read port (read-old).
// Takes its default width and depth from sss_pkg.
module sss_ram
    import sss_pkg::*;
#(
    parameter int WIDTH = ID_W,
    parameter int DEPTH = DEF_MAX_ENTITIES
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read; a same-edge read returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/signature_sparse_set.sv
// Top level of the signature sparse set: packed member list, slot map, member bits.
// Depends on sss_pkg and sss_ram.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in      | input     | in_valid / in_ready     | entity_id, component_mask
//  out     | output    | out_valid / out_ready   | action, slot, moved_entity, member_count
//  cfg     | input     | cfg_wr_en (no wait)     | cfg_wr_data -> system_mask
//
// One request per cycle sustained unless the output stalls; the result is registered
// from the execute stage (RAM read at acceptance, decision and write-back in the
// execute stage). The hazard between back-to-back requests is closed by forwarding
// the last write-back of each RAM; the tail entry of the packed list is read every cycle.
// After reset the member bit RAM is swept to zero with in_ready low; configuration
// writes are taken throughout.
// A stalled output holds the execute stage, which in turn holds in_ready low.
module signature_sparse_set
    import sss_pkg::*;
#(
    parameter int MAX_ENTITIES = DEF_MAX_ENTITIES,
    parameter int MASK_WIDTH   = DEF_MASK_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [MASK_W-1:0]    cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ID_W-1:0]      entity_id,
    input  logic [MASK_W-1:0]    component_mask,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ACT_W-1:0]     action,
    output logic [ID_W-1:0]      slot,
    output logic [ID_W-1:0]      moved_entity,
    output logic [CNT_OUT_W-1:0] member_count
);

    localparam int AW    = $clog2(MAX_ENTITIES);
    localparam int CNT_W = $clog2(MAX_ENTITIES + 1);
    localparam logic [63:0] SIG_SEL64 = (MASK_WIDTH >= 64) ? '1 :
                                        ((64'd1 << MASK_WIDTH) - 64'd1);
    localparam logic [MASK_W-1:0] SIG_SEL = SIG_SEL64[MASK_W-1:0];

    // Configuration
    logic [MASK_W-1:0] sys_mask_reg;

    // Clearing sweep
    logic          clear_reg;
    logic [AW-1:0] clr_addr_reg;

    // Execute stage
    logic              s1_valid_reg;
    logic              s1_inr_reg;
    logic [AW-1:0]     s1_id_reg;
    logic [MASK_W-1:0] s1_mask_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // Forwarding records of the last write-back
    logic          sm_we_reg, mb_we_reg, mb_data_reg, pl_hit_reg;
    logic [AW-1:0] sm_addr_reg, sm_data_reg, mb_addr_reg, pl_byp_reg;

    // Output register
    logic                 out_valid_reg;
    action_t              action_reg;
    logic [ID_W-1:0]      slot_reg, moved_reg;
    logic [CNT_OUT_W-1:0] cnt_out_reg;

    // RAM ports
    logic          pl_we, sm_we, mb_we, mb_wdata, mb_rdata;
    logic [AW-1:0] pl_waddr, pl_wdata, pl_raddr, pl_rdata;
    logic [AW-1:0] sm_waddr, sm_wdata, sm_rdata, mb_waddr;

    logic              in_accept, s1_fire, do_add, do_rem, is_mem, covers;
    logic [AW-1:0]     s_fwd, tail, last_id;
    logic [MASK_W-1:0] need;
    logic [31:0]       id32, slot32, moved32, cnt32;

    assign in_accept = in_valid && in_ready;
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !clear_reg && (!s1_valid_reg || s1_fire);
    assign id32      = 32'(entity_id);

    // Memories
    sss_ram #(.WIDTH(AW), .DEPTH(MAX_ENTITIES)) u_packed_list
    (
        .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
        .re(1'b1), .raddr(pl_raddr), .rdata(pl_rdata)
    );

    sss_ram #(.WIDTH(AW), .DEPTH(MAX_ENTITIES)) u_slot_map
    (
        .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
        .re(in_accept), .raddr(id32[AW-1:0]), .rdata(sm_rdata)
    );

    sss_ram #(.WIDTH(1), .DEPTH(MAX_ENTITIES)) u_member
    (
        .clk(clk), .we(mb_we), .waddr(mb_waddr), .wdata(mb_wdata),
        .re(in_accept), .raddr(id32[AW-1:0]), .rdata(mb_rdata)
    );

    // Forwarded lookups and the decision
    always_comb
    begin
        is_mem  = (mb_we_reg && mb_addr_reg == s1_id_reg) ? mb_data_reg : mb_rdata;
        s_fwd   = (sm_we_reg && sm_addr_reg == s1_id_reg) ? sm_data_reg : sm_rdata;
        tail    = pl_hit_reg ? pl_byp_reg : pl_rdata;
        last_id = (32'(tail) >= MAX_ENTITIES) ? '0 : tail;
        need    = sys_mask_reg & SIG_SEL;
        covers  = ((s1_mask_reg & need) == need);
        do_add  = s1_inr_reg && covers && !is_mem
                  && (count_reg < CNT_W'(MAX_ENTITIES));
        do_rem  = s1_inr_reg && !covers && is_mem
                  && (count_reg != '0) && (CNT_W'(s_fwd) < count_reg);
    end

    // Write-back and next count
    always_comb
    begin
        count_next = count_reg;
        pl_we      = 1'b0;
        pl_waddr   = count_reg[AW-1:0];
        pl_wdata   = s1_id_reg;
        sm_we      = 1'b0;
        sm_waddr   = s1_id_reg;
        sm_wdata   = count_reg[AW-1:0];
        mb_we      = 1'b0;
        mb_waddr   = s1_id_reg;
        mb_wdata   = 1'b0;
        if (clear_reg)
        begin
            mb_we    = 1'b1;
            mb_waddr = clr_addr_reg;
        end
        else if (s1_fire && do_add)
        begin
            pl_we      = 1'b1;
            sm_we      = 1'b1;
            mb_we      = 1'b1;
            mb_wdata   = 1'b1;
            count_next = count_reg + CNT_W'(1);
        end
        else if (s1_fire && do_rem)
        begin
            pl_we      = 1'b1;
            pl_waddr   = s_fwd;
            pl_wdata   = last_id;
            sm_we      = 1'b1;
            sm_waddr   = last_id;
            sm_wdata   = s_fwd;
            mb_we      = 1'b1;
            count_next = count_reg - CNT_W'(1);
        end
        pl_raddr = AW'(count_next - CNT_W'(1));
    end

    // Result fields
    always_comb
    begin
        slot32  = do_add ? 32'(count_reg) : (do_rem ? 32'(s_fwd) : 32'd0);
        moved32 = do_rem ? 32'(last_id) : 32'd0;
        cnt32   = 32'(count_next);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_mask_reg  <= '0;
            clear_reg     <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            count_reg     <= '0;
            sm_we_reg     <= 1'b0;
            mb_we_reg     <= 1'b0;
            pl_hit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                sys_mask_reg <= cfg_wr_data;
            end
            if (clear_reg)
            begin
                if (clr_addr_reg == AW'(MAX_ENTITIES - 1))
                begin
                    clear_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            count_reg  <= count_next;
            pl_hit_reg <= pl_we && (pl_waddr == pl_raddr);
            if (s1_fire)
            begin
                sm_we_reg <= sm_we;
                mb_we_reg <= mb_we;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pl_byp_reg <= pl_wdata;
        if (in_accept)
        begin
            s1_inr_reg  <= (id32 < MAX_ENTITIES);
            s1_id_reg   <= id32[AW-1:0];
            s1_mask_reg <= component_mask & SIG_SEL;
        end
        if (s1_fire)
        begin
            sm_addr_reg <= sm_waddr;
            sm_data_reg <= sm_wdata;
            mb_addr_reg <= mb_waddr;
            mb_data_reg <= mb_wdata;
            action_reg  <= do_add ? ACT_ADDED : (do_rem ? ACT_REMOVED : ACT_NONE);
            slot_reg    <= slot32[ID_W-1:0];
            moved_reg   <= moved32[ID_W-1:0];
            cnt_out_reg <= cnt32[CNT_OUT_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign action       = action_reg;
    assign slot         = slot_reg;
    assign moved_entity = moved_reg;
    assign member_count = cnt_out_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTITIES))
        else $error("member count above capacity");

    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && do_add) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("add did not bump the count");

    a_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && do_rem) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("remove did not drop the count");

    a_no_work_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> !s1_valid_reg)
        else $error("request in flight during the clearing sweep");

    a_add_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && do_add) |=> (32'(slot_reg) == (32'(cnt_out_reg) - 32'd1) % 32'd1024))
        else $error("added slot is not the last one");

endmodule

FILE: bench/tb.sv
// Testbench for signature_sparse_set: a queued request driver, a result monitor
// and a predictor of the sparse member list. Depends on sss_pkg and the RTL top.
`timescale 1ns / 1ps

module tb
    import sss_pkg::*;
();

    localparam int N_ENT      = DEF_MAX_ENTITIES;
    localparam int CYCLE_CAP  = 400000;
    localparam int SETTLE_CYC = 4;
    localparam int TAIL_CYC   = 20;
    localparam int MISMATCH_SHOWN = 10;

    // Idle profiles, applied in this order over the random part
    localparam int MODE_SLOW_RX = 0;
    localparam int MODE_SLOW_TX = 1;
    localparam int MODE_FREE    = 2;

    typedef enum logic [1:0] {
        REQ_ITEM,
        REQ_CFG,
        REQ_HOLD
    } req_kind_t;

    typedef struct {
        req_kind_t        kind;
        logic [ID_W-1:0]  id;
        logic [MASK_W-1:0] data;
        int               mode;
    } pending_req_t;

    typedef struct packed {
        action_t              act;
        logic [ID_W-1:0]      slot;
        logic [ID_W-1:0]      moved;
        logic [CNT_OUT_W-1:0] cnt;
    } member_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [MASK_W-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [ID_W-1:0] entity_id = '0;
    logic [MASK_W-1:0] component_mask = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0] slot;
    logic [ID_W-1:0] moved_entity;
    logic [CNT_OUT_W-1:0] member_count;

    pending_req_t   pending[$];
    member_result_t expected_results[$];
    logic in_hs = 1'b0;
    int   cur_mode = MODE_SLOW_RX;
    int   quiet_cycles = 0;
    int   mismatches = 0;
    int   cycle_count = 0;

    // Predictor state
    logic [ID_W-1:0]   pred_packed[N_ENT];
    logic [ID_W-1:0]   pred_slot_of[N_ENT];
    logic [N_ENT-1:0]  pred_member = '0;
    int                pred_count = 0;
    logic [MASK_W-1:0] pred_sys_mask = '0;

    signature_sparse_set DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .entity_id      (entity_id),
        .component_mask (component_mask),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .action         (action),
        .slot           (slot),
        .moved_entity   (moved_entity),
        .member_count   (member_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one signature update to the predicted set and return the result
    function automatic member_result_t apply_signature(logic [ID_W-1:0] id,
                                                       logic [MASK_W-1:0] sig);
        member_result_t r;
        logic covers;
        int s;
        logic [ID_W-1:0] last;
        r = '0;
        r.act = ACT_NONE;
        covers = ((sig & pred_sys_mask) == pred_sys_mask);
        if (covers && !pred_member[id])
        begin
            if (pred_count < N_ENT)
            begin
                r.slot = pred_count[ID_W-1:0];
                pred_packed[pred_count] = id;
                pred_slot_of[id] = pred_count[ID_W-1:0];
                pred_member[id] = 1'b1;
                pred_count++;
                r.act = ACT_ADDED;
            end
        end
        else if (!covers && pred_member[id])
        begin
            s = pred_slot_of[id];
            if (pred_count > 0 && s < pred_count)
            begin
                last = pred_packed[pred_count-1];
                pred_packed[s] = last;
                pred_slot_of[last] = s[ID_W-1:0];
                pred_member[id] = 1'b0;
                pred_count--;
                r.slot = s[ID_W-1:0];
                r.moved = last;
                r.act = ACT_REMOVED;
            end
        end
        r.cnt = pred_count[CNT_OUT_W-1:0];
        return r;
    endfunction

    // Signature that covers m when keep is set or m is empty, otherwise misses one bit of m
    function automatic logic [MASK_W-1:0] gen_signature(logic [MASK_W-1:0] m, bit keep);
        int b;
        if (keep || m == '0)
            return $urandom() | m;
        do
            b = $urandom_range(MASK_W-1);
        while (!m[b]);
        return ($urandom() | m) & ~(32'h1 << b);
    endfunction

    task automatic push_item(logic [ID_W-1:0] id, logic [MASK_W-1:0] sig, int mode);
        pending_req_t p;
        p.kind = REQ_ITEM;
        p.id   = id;
        p.data = sig;
        p.mode = mode;
        pending.insert(pending.size(), p);
    endtask

    task automatic push_cfg(logic [MASK_W-1:0] m);
        pending_req_t p;
        p.kind = REQ_CFG;
        p.id   = '0;
        p.data = m;
        p.mode = MODE_FREE;
        pending.insert(pending.size(), p);
    endtask

    task automatic push_hold();
        pending_req_t p;
        p.kind = REQ_HOLD;
        p.id   = '0;
        p.data = '0;
        p.mode = MODE_FREE;
        pending.insert(pending.size(), p);
    endtask

    // Driver: requests and register writes change on the falling edge
    always @(negedge clk)
    begin
        logic want_valid;
        logic want_cfg;
        logic rx_ready;
        int   tx_idle;
        int   rx_idle;
        want_valid = in_valid;
        want_cfg   = 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_hs)
                want_valid = 1'b0;
            if (expected_results.size() == 0 && !want_valid)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!want_valid && pending.size() > 0)
            begin
                case (pending[0].kind)
                    REQ_ITEM:
                    begin
                        tx_idle = (pending[0].mode == MODE_SLOW_RX) ? 18 :
                                  (pending[0].mode == MODE_SLOW_TX) ? 79 : 0;
                        if ($urandom_range(99) >= tx_idle)
                        begin
                            entity_id      <= pending[0].id;
                            component_mask <= pending[0].data;
                            cur_mode       <= pending[0].mode;
                            want_valid = 1'b1;
                            void'(pending.pop_front());
                        end
                    end
                    REQ_CFG:
                    begin
                        // block must be drained before the mask changes
                        if (quiet_cycles >= SETTLE_CYC)
                        begin
                            cfg_wr_data <= pending[0].data;
                            want_cfg = 1'b1;
                            quiet_cycles = 0;
                            void'(pending.pop_front());
                        end
                    end
                    default:
                    begin
                        if (quiet_cycles >= SETTLE_CYC)
                            void'(pending.pop_front());
                    end
                endcase
            end
        end
        rx_idle = (cur_mode == MODE_SLOW_RX) ? 79 : (cur_mode == MODE_SLOW_TX) ? 18 : 0;
        rx_ready = ($urandom_range(99) >= rx_idle);
        in_valid  <= want_valid;
        cfg_wr_en <= want_cfg;
        out_ready <= rx_ready;
    end

    // Monitor: register writes, accepted requests and results on the rising edge
    always @(posedge clk)
    begin
        member_result_t got;
        member_result_t exp_r;
        in_hs <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (cfg_wr_en)
                pred_sys_mask = cfg_wr_data;
            if (out_valid && out_ready)
            begin
                got.act   = action_t'(action);
                got.slot  = slot;
                got.moved = moved_entity;
                got.cnt   = member_count;
                if (expected_results.size() == 0)
                begin
                    if (mismatches < MISMATCH_SHOWN)
                        $display("unexpected result: act=%0d slot=%0d moved=%0d count=%0d",
                                 action, slot, moved_entity, member_count);
                    mismatches++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got.act !== exp_r.act || got.slot !== exp_r.slot ||
                        got.moved !== exp_r.moved || got.cnt !== exp_r.cnt)
                    begin
                        if (mismatches < MISMATCH_SHOWN)
                            $display({"mismatch: expected act=%0d slot=%0d moved=%0d ",
                                      "count=%0d, got act=%0d slot=%0d moved=%0d count=%0d"},
                                     exp_r.act, exp_r.slot, exp_r.moved, exp_r.cnt,
                                     action, slot, moved_entity, member_count);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.insert(expected_results.size(),
                                        apply_signature(entity_id, component_mask));
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus plan, reset and end of run
    initial
    begin
        logic [ID_W-1:0]   order[N_ENT];
        logic [ID_W-1:0]   tmp;
        logic [MASK_W-1:0] m;
        int j;
        int k;
        int n_rand;

        // Directed: empty mask, everything covers
        push_cfg(32'h0000_0000);
        push_item(10'd0,    32'h0000_0000, MODE_SLOW_RX);
        push_item(10'd1023, 32'hFFFF_FFFF, MODE_SLOW_RX);
        push_item(10'd0,    32'h1234_5678, MODE_SLOW_RX);
        push_item(10'd5,    32'h0000_0000, MODE_SLOW_RX);
        // Directed: full mask, removals with and without a move
        push_cfg(32'hFFFF_FFFF);
        push_item(10'd1023, 32'hFFFF_FFFF, MODE_SLOW_RX);
        push_item(10'd0,    32'hFFFF_FFFE, MODE_SLOW_RX);
        push_item(10'd5,    32'h7FFF_FFFF, MODE_SLOW_RX);
        push_item(10'd1023, 32'h0000_0000, MODE_SLOW_RX);
        push_item(10'd1023, 32'h0000_0000, MODE_SLOW_RX);
        push_item(10'd7,    32'hFFFF_FFFF, MODE_SLOW_RX);
        push_item(10'd7,    32'hFFFF_FFFF, MODE_SLOW_RX);
        // Directed: edge bits of the mask
        push_cfg(32'h8000_0001);
        push_item(10'd8,    32'h8000_0001, MODE_SLOW_RX);
        push_item(10'd9,    32'h8000_0000, MODE_SLOW_RX);
        push_item(10'd10,   32'hFFFF_FFFF, MODE_SLOW_RX);
        push_item(10'd8,    32'h0000_0001, MODE_SLOW_RX);
        push_item(10'd7,    32'h8000_0001, MODE_SLOW_RX);
        push_item(10'd10,   32'h7FFF_FFFE, MODE_SLOW_RX);
        push_item(10'd7,    32'h0000_0000, MODE_SLOW_RX);

        n_rand = 100 + N_ENT + 250 + 50;
        k = 0;

        // Random: mask of up to two bits, redrawn halfway, small id pool so adds and removes alternate
        m = (32'h1 << $urandom_range(31)) | (32'h1 << $urandom_range(31));
        push_cfg(m);
        for (int i = 0; i < 100; i++)
        begin
            if (i == 50)
            begin
                push_hold();
                m = (32'h1 << $urandom_range(31)) | (32'h1 << $urandom_range(31));
                push_cfg(m);
            end
            push_item(($urandom_range(9) == 0) ? ID_W'($urandom()) : ID_W'($urandom_range(31)),
                      ($urandom_range(9) == 0) ? $urandom() :
                          gen_signature(m, $urandom_range(1) == 0),
                      (k * 3) / n_rand);
            k++;
        end

        // Random: empty mask, every id in shuffled order fills the set
        for (int i = 0; i < N_ENT; i++)
            order[i] = i[ID_W-1:0];
        for (int i = N_ENT - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        push_cfg(32'h0000_0000);
        for (int i = 0; i < N_ENT; i++)
        begin
            push_item(order[i], $urandom(), (k * 3) / n_rand);
            k++;
        end

        // Random: single-bit mask, removals across the full list
        m = 32'h1 << $urandom_range(31);
        push_cfg(m);
        for (int i = 0; i < 250; i++)
        begin
            push_item(ID_W'($urandom()), gen_signature(m, $urandom_range(2) == 0),
                      (k * 3) / n_rand);
            k++;
        end

        // Random: full mask, small pool
        push_cfg(32'hFFFF_FFFF);
        for (int i = 0; i < 50; i++)
        begin
            push_item(ID_W'($urandom_range(15)),
                      ($urandom_range(1) == 0) ? 32'hFFFF_FFFF :
                          gen_signature(32'hFFFF_FFFF, 1'b0),
                      (k * 3) / n_rand);
            k++;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
